/* rtl/pvi_pkg.sv */
// Shared types and constants for the pulse-width to velocity interpolator.
`default_nettype none

package pvi_pkg;

    localparam int NUM_POINTS_DEFAULT = 5;
    localparam int NUM_REGS           = 5;
    localparam int PW_W               = 12;
    localparam int VEL_W              = 16;
    localparam int POINT_W            = 28;
    localparam int CFG_IDX_W          = 3;
    localparam int DY_W               = 17;
    localparam int PROD_W             = 30;
    localparam int MAG_W              = 28;
    localparam int QUO_W              = 17;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [POINT_W-1:0] POINT_RESET [NUM_REGS] = '{
        28'd226493816, 28'd1500, 28'd41944640, 28'd58721956, 28'd75499272
    };

    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2
    } range_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] base;
        logic signed [DY_W-1:0]  dy;
        logic [PW_W-1:0]         num;
        logic [PW_W-1:0]         dx;
        range_t                  status;
    } pvi_job_t;

endpackage

`default_nettype wire

/* rtl/pvi_front.sv */
// Breakpoint registers and segment classification of incoming pulse widths.
`default_nettype none

module pvi_front #(
    parameter int NUM_POINTS = pvi_pkg::NUM_POINTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [pvi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pvi_pkg::POINT_W-1:0]   cfg_data,
    input  wire logic [pvi_pkg::PW_W-1:0]      pwm_width,
    output pvi_pkg::pvi_job_t                  job
);
    import pvi_pkg::*;

    logic [POINT_W-1:0]      point_reg [NUM_POINTS];
    logic [PW_W-1:0]         xs [NUM_POINTS];
    logic signed [VEL_W-1:0] ys [NUM_POINTS];
    logic [PW_W-1:0]         seg_x0;
    logic [PW_W-1:0]         seg_x1;
    logic signed [VEL_W-1:0] seg_y0;
    logic signed [VEL_W-1:0] seg_y1;

    for (genvar k = 0; k < NUM_POINTS; k++) begin : g_point
        if (k < NUM_REGS) begin : g_writable
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    point_reg[k] <= POINT_RESET[k];
                end
                else if (cfg_valid && cfg_index == CFG_IDX_W'(k))
                begin
                    point_reg[k] <= cfg_data;
                end
            end
        end
        else begin : g_fixed
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    point_reg[k] <= '0;
                end
                else
                begin
                    point_reg[k] <= '0;
                end
            end
        end
        assign xs[k] = point_reg[k][PW_W-1:0];
        assign ys[k] = $signed(point_reg[k][PW_W+VEL_W-1:PW_W]);
    end

    always_comb
    begin
        logic found;
        found  = 1'b0;
        seg_x0 = xs[0];
        seg_x1 = xs[0];
        seg_y0 = ys[0];
        seg_y1 = ys[0];
        for (int i = 0; i < NUM_POINTS - 1; i++)
        begin
            if (!found && xs[i] < pwm_width && pwm_width <= xs[i+1])
            begin
                found  = 1'b1;
                seg_x0 = xs[i];
                seg_x1 = xs[i+1];
                seg_y0 = ys[i];
                seg_y1 = ys[i+1];
            end
        end
    end

    always_comb
    begin
        priority if (pwm_width <= xs[0])
        begin
            job.base   = ys[0];
            job.dy     = '0;
            job.num    = '0;
            job.dx     = PW_W'(1);
            job.status = ST_BELOW;
        end
        else if (pwm_width >= xs[NUM_POINTS-1])
        begin
            job.base   = ys[NUM_POINTS-1];
            job.dy     = '0;
            job.num    = '0;
            job.dx     = PW_W'(1);
            job.status = ST_ABOVE;
        end
        else
        begin
            job.base   = seg_y0;
            job.dy     = DY_W'(seg_y1) - DY_W'(seg_y0);
            job.num    = pwm_width - seg_x0;
            job.dx     = seg_x1 - seg_x0;
            job.status = ST_INSIDE;
        end
    end

endmodule

`default_nettype wire

/* rtl/pvi_queue.sv */
// Short queue of classified jobs between the front and the back.
`default_nettype none

module pvi_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  pvi_pkg::pvi_job_t  push_job,
    output logic               full,
    output logic               pop_valid,
    output pvi_pkg::pvi_job_t  pop_job
);
    import pvi_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pvi_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop       = (count_reg != '0);
    assign pop_valid = pop;
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        push && count_reg == '0 |=> pop_valid)
        else $error("pushed job not visible at the head");

endmodule

`default_nettype wire

/* rtl/pvi_back.sv */
// Multiply, pipelined restoring divide and final offset of interpolation jobs.
`default_nettype none

module pvi_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  pvi_pkg::pvi_job_t                   in_job,
    output logic                                done,
    output logic signed [pvi_pkg::VEL_W-1:0]    velocity,
    output logic [1:0]                          range_status
);
    import pvi_pkg::*;

    localparam int DIV_STEPS = MAG_W;
    localparam int LAT       = DIV_STEPS + 3;

    typedef struct packed {
        logic [PW_W-1:0]         rem;
        logic [MAG_W-1:0]        dvd;
        logic [MAG_W-1:0]        quo;
        logic [PW_W-1:0]         dx;
        logic signed [VEL_W-1:0] base;
        logic                    neg;
        range_t                  status;
    } pvi_div_t;

    function automatic pvi_div_t div_step(pvi_div_t s);
        logic [PW_W:0] trial;
        pvi_div_t      r;
        r     = s;
        trial = {s.rem, s.dvd[MAG_W-1]};
        r.dvd = {s.dvd[MAG_W-2:0], 1'b0};
        if (trial >= {1'b0, s.dx})
        begin
            r.rem = PW_W'(trial - {1'b0, s.dx});
            r.quo = {s.quo[MAG_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[PW_W-1:0];
            r.quo = {s.quo[MAG_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;
    logic [PW_W-1:0]          mul_dx_reg;
    logic signed [VEL_W-1:0]  mul_base_reg;
    range_t                   mul_status_reg;
    logic signed [PROD_W-1:0] mag_full;
    pvi_div_t                 div_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]       div_valid_reg;
    logic signed [QUO_W:0]    quo_signed;
    logic signed [VEL_W+1:0]  vel_sum;
    logic                     done_reg;
    logic signed [VEL_W-1:0]  velocity_reg;
    range_t                   status_reg;

    always_ff @(posedge clk)
    begin
        mul_prod_reg   <= PROD_W'(in_job.dy) * PROD_W'($signed({1'b0, in_job.num}));
        mul_dx_reg     <= in_job.dx;
        mul_base_reg   <= in_job.base;
        mul_status_reg <= in_job.status;
    end

    assign mag_full = mul_prod_reg[PROD_W-1] ? -mul_prod_reg : mul_prod_reg;

    always_ff @(posedge clk)
    begin
        div_reg[0].rem    <= '0;
        div_reg[0].dvd    <= mag_full[MAG_W-1:0];
        div_reg[0].quo    <= '0;
        div_reg[0].dx     <= mul_dx_reg;
        div_reg[0].base   <= mul_base_reg;
        div_reg[0].neg    <= mul_prod_reg[PROD_W-1];
        div_reg[0].status <= mul_status_reg;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_ff @(posedge clk)
        begin
            div_reg[k+1] <= div_step(div_reg[k]);
        end
    end

    assign quo_signed = div_reg[DIV_STEPS].neg
                      ? -$signed({1'b0, div_reg[DIV_STEPS].quo[QUO_W-1:0]})
                      :  $signed({1'b0, div_reg[DIV_STEPS].quo[QUO_W-1:0]});
    assign vel_sum    = (VEL_W+2)'(div_reg[DIV_STEPS].base) + (VEL_W+2)'(quo_signed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            div_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-1:0], mul_valid_reg};
            done_reg      <= div_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        velocity_reg <= vel_sum[VEL_W-1:0];
        status_reg   <= div_reg[DIV_STEPS].status;
    end

    assign done         = done_reg;
    assign velocity     = velocity_reg;
    assign range_status = status_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(in_valid, LAT))
        else $error("result without a job entering the pipeline");

    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> in_job.dx != '0)
        else $error("job with a zero width difference");

    a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DIV_STEPS] && div_reg[DIV_STEPS].status != ST_INSIDE
        |-> div_reg[DIV_STEPS].quo == '0)
        else $error("clamped job with a nonzero quotient");

endmodule

`default_nettype wire

/* rtl/pwm_to_velocity_interpolator_unit.sv */
// Top level of the pulse-width to velocity interpolator.
//
// Channel     Direction  Handshake                 Payload
// command     in         start, busy               pwm_width
// result      out        done (one-cycle strobe)   velocity, range_status
// config      in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One command is taken every cycle while busy is low; the back end is a
// fully pipelined 28-stage restoring divider after a single multiplier stage.
// A result passes in order through the queue register, one multiply stage,
// one magnitude stage, 28 divide stages and the output register.
// Reset clears the breakpoints to their defaults and empties the pipeline.
// The result side cannot stall; busy rises only if the queue fills.
`default_nettype none

module pwm_to_velocity_interpolator_unit #(
    parameter int NUM_POINTS = pvi_pkg::NUM_POINTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pvi_pkg::PW_W-1:0]      pwm_width,
    output logic                               done,
    output logic signed [pvi_pkg::VEL_W-1:0]   velocity,
    output logic [1:0]                         range_status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pvi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pvi_pkg::POINT_W-1:0]   cfg_data
);
    import pvi_pkg::*;

    pvi_job_t front_job;
    pvi_job_t back_job;
    logic     queue_full;
    logic     back_valid;
    logic     push;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;

    pvi_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pwm_width (pwm_width),
        .job       (front_job)
    );

    pvi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .full      (queue_full),
        .pop_valid (back_valid),
        .pop_job   (back_job)
    );

    pvi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (back_valid),
        .in_job       (back_job),
        .done         (done),
        .velocity     (velocity),
        .range_status (range_status)
    );

endmodule

`default_nettype wire

/* tb/pwm_to_velocity_interpolator_unit_tb.sv */
// Self-checking testbench: drives widths and breakpoint tables, predicts each velocity, checks it.
`default_nettype none

module pwm_to_velocity_interpolator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pvi_pkg::*;

    localparam int PIPE_LATENCY   = 32;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 220;
    localparam int LAST_INDEX     = (1 << CFG_IDX_W) - 1;
    localparam int MAX_WIDTH      = (1 << PW_W) - 1;
    localparam realtime RUN_LIMIT = 3ms;

    localparam int TABLE_CLUSTERED = 0;
    localparam int TABLE_SORTED    = 1;
    localparam int TABLE_SHUFFLED  = 2;

    typedef struct {
        logic signed [VEL_W-1:0] vel;
        range_t                  status;
    } motion_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PW_W-1:0]        pwm_width = '0;
    logic                   done;
    logic signed [VEL_W-1:0] velocity;
    logic [1:0]             range_status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [POINT_W-1:0]     cfg_data = '0;

    logic [POINT_W-1:0] point_table [NUM_REGS];
    motion_t            motion_expect_q [$];
    motion_t            want;
    int                 error_count = 0;
    int                 widths_sent = 0;
    int                 results_seen = 0;
    int                 point_writes = 0;
    int                 tables_used = 1;
    bit                 gaps_on = 1'b0;

    pwm_to_velocity_interpolator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pwm_width    (pwm_width),
        .done         (done),
        .velocity     (velocity),
        .range_status (range_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, motion_expect_q.size());
        $display("pwm_to_velocity_interpolator_unit test failed");
        $finish;
    end

    function automatic logic [POINT_W-1:0] pack_point(input int x, input int y);
        return {y[VEL_W-1:0], x[PW_W-1:0]};
    endfunction

    function automatic motion_t interpolate_velocity(input logic [PW_W-1:0] w);
        motion_t m;
        int      wi;
        int      x0;
        int      x1;
        longint  y0;
        longint  y1;
        longint  q;
        bit      found;
        wi = int'(w);
        found = 1'b0;
        m.vel = '0;
        if (wi <= int'(point_table[0][PW_W-1:0]))
        begin
            m.vel = point_table[0][POINT_W-1:PW_W];
            m.status = ST_BELOW;
        end
        else if (wi >= int'(point_table[NUM_REGS-1][PW_W-1:0]))
        begin
            m.vel = point_table[NUM_REGS-1][POINT_W-1:PW_W];
            m.status = ST_ABOVE;
        end
        else
        begin
            m.status = ST_INSIDE;
            for (int i = 0; i < NUM_REGS - 1; i++)
            begin
                x0 = int'(point_table[i][PW_W-1:0]);
                x1 = int'(point_table[i+1][PW_W-1:0]);
                if (!found && x0 < wi && wi <= x1)
                begin
                    y0 = longint'($signed(point_table[i][POINT_W-1:PW_W]));
                    y1 = longint'($signed(point_table[i+1][POINT_W-1:PW_W]));
                    q = ((y1 - y0) * longint'(wi - x0)) / longint'(x1 - x0);
                    m.vel = VEL_W'(y0 + q);
                    found = 1'b1;
                end
            end
        end
        return m;
    endfunction

    // Result checker: each strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (motion_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual velocity %0d status %0d",
                         $time, velocity, range_status);
                error_count++;
            end
            else
            begin
                want = motion_expect_q.pop_front();
                if (velocity !== want.vel)
                begin
                    $display("%0t: velocity mismatch, expected %0d, actual %0d",
                             $time, want.vel, velocity);
                    error_count++;
                end
                if (range_status !== want.status)
                begin
                    $display("%0t: range_status mismatch, expected %0d, actual %0d",
                             $time, want.status, range_status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_width(input int w);
        start = 1'b1;
        pwm_width = PW_W'(w);
        do @(posedge clk); while (busy);
        motion_expect_q.push_back(interpolate_velocity(PW_W'(w)));
        widths_sent++;
        @(negedge clk);
        if (gaps_on && $urandom_range(3, 0) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        start = 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && motion_expect_q.size() != 0; n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_point(input int idx, input logic [POINT_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx[CFG_IDX_W-1:0];
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < NUM_REGS)
            point_table[idx] = data;
        point_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_table(input int xs [NUM_REGS], input int ys [NUM_REGS]);
        wait_for_results();
        for (int k = 0; k < NUM_REGS; k++)
            write_point(k, pack_point(xs[k], ys[k]));
        tables_used++;
    endtask

    task automatic test_reset_table();
        int widths [12] = '{0, 1365, 1400, 1401, 1450, 1500, 1550, 1600, 1799, 1800,
                            2730, MAX_WIDTH};
        foreach (widths[i])
            send_width(widths[i]);
    endtask

    task automatic test_extreme_tables();
        int widths [6] = '{0, 1, 2, 1024, MAX_WIDTH - 1, MAX_WIDTH};
        load_table('{0, 1, 2048, MAX_WIDTH - 1, MAX_WIDTH},
                   '{-32768, 32767, -32768, 32767, -1});
        foreach (widths[i])
            send_width(widths[i]);
    endtask

    task automatic test_degenerate_tables();
        load_table('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0});
        send_width(0);
        send_width(MAX_WIDTH);
        load_table('{MAX_WIDTH, MAX_WIDTH, MAX_WIDTH, MAX_WIDTH, MAX_WIDTH},
                   '{-1, -1, -1, -1, -1});
        send_width(0);
        send_width(MAX_WIDTH);
    endtask

    task automatic test_unordered_table();
        load_table('{100, 3000, 500, 3500, 4000}, '{4096, -8192, 32767, -32768, 256});
        send_width(400);
        send_width(2000);
        send_width(3200);
    endtask

    task automatic test_unused_indexes();
        wait_for_results();
        for (int idx = NUM_REGS; idx <= LAST_INDEX; idx++)
            write_point(idx, POINT_W'($urandom));
        send_width(2000);
    endtask

    task automatic test_random_tables();
        int xs [NUM_REGS];
        int ys [NUM_REGS];
        int sorted_x [$];
        int base;
        int lo;
        int hi;
        int kind;
        int w;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            kind = phase % 3;
            sorted_x.delete();
            base = $urandom_range(MAX_WIDTH - 16, 0);
            for (int k = 0; k < NUM_REGS; k++)
            begin
                if (kind == TABLE_CLUSTERED)
                    sorted_x.push_back(base + $urandom_range(16, 0));
                else
                    sorted_x.push_back($urandom_range(MAX_WIDTH, 0));
                case ($urandom_range(5, 0))
                    0:       ys[k] = -32768;
                    1:       ys[k] = 32767;
                    default: ys[k] = int'($signed(VEL_W'($urandom)));
                endcase
            end
            if (kind != TABLE_SHUFFLED)
                sorted_x.sort();
            lo = MAX_WIDTH;
            hi = 0;
            for (int k = 0; k < NUM_REGS; k++)
            begin
                xs[k] = sorted_x[k];
                if (xs[k] < lo)
                    lo = xs[k];
                if (xs[k] > hi)
                    hi = xs[k];
            end
            lo = (lo < 20) ? 0 : lo - 20;
            hi = (hi > MAX_WIDTH - 20) ? MAX_WIDTH : hi + 20;
            load_table(xs, ys);
            write_point($urandom_range(LAST_INDEX, NUM_REGS), POINT_W'($urandom));
            gaps_on = (phase != RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(4, 0) == 0)
                    w = $urandom_range(MAX_WIDTH, 0);
                else
                    w = $urandom_range(hi, lo);
                send_width(w);
            end
        end
        gaps_on = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < NUM_REGS; k++)
            point_table[k] = POINT_RESET[k];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_table();
        test_extreme_tables();
        test_degenerate_tables();
        test_unordered_table();
        test_unused_indexes();
        test_random_tables();

        wait_for_results();
        if (motion_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, motion_expect_q.size());
            error_count++;
        end
        $display("Ran %0d pulse widths through %0d breakpoint tables with %0d register writes.",
                 widths_sent, tables_used, point_writes);
        $display("Checked %0d results; %0d errors found.", results_seen, error_count);
        if (error_count == 0)
            $display("pwm_to_velocity_interpolator_unit test passed");
        else
            $display("pwm_to_velocity_interpolator_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
